/* rtl/udpdns_pkg.sv */
// shared types, constants and register map of the udp dns extractor
`default_nettype none
package udpdns_pkg;

	// payload window per packet, power of two
	localparam int unsigned PAYLOAD_SIZE = 512;
	localparam logic [16:0] PAYLOAD_MASK = 17'(PAYLOAD_SIZE - 1);

	// protocol constants
	localparam logic [7:0] IP_VERSION_4   = 8'd4;
	localparam logic [5:0] IP_HDR_MIN     = 6'd20;
	localparam logic [7:0] IP_PROTO_UDP   = 8'd17;
	localparam logic [6:0] UDP_HDR_LEN    = 7'd8;
	localparam logic [6:0] DNS_HDR_LEN    = 7'd12;
	localparam logic [15:0] OFF_FRAG_HI   = 16'd6;
	localparam logic [15:0] OFF_FRAG_LO   = 16'd7;
	localparam logic [15:0] OFF_PROTO     = 16'd9;
	localparam logic [15:0] OFF_SRC_ADDR  = 16'd12;
	localparam logic [15:0] OFF_DST_ADDR  = 16'd16;
	localparam logic [15:0] OFF_ADDR_END  = 16'd20;
	localparam logic [15:0] OFF_MAX       = 16'hFFFF;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EVENT   = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;

	// register map
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_MATCH_PORT = 3'd0;
	localparam logic [15:0] MATCH_PORT_RESET = 16'd53;

	// result queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  pkt_byte;
		logic        first_byte;
		logic        last_byte;
		logic [63:0] time_now;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] dns_ident;
		logic [15:0] dns_flags;
		logic [15:0] question_count;
		logic [15:0] answer_count;
		logic [8:0]  msg_len;
		logic [63:0] timestamp;
	} out_item_t;

	// up to two results from one byte, payload first
	typedef struct packed {
		logic      pay_vld;
		logic      vrd_vld;
		out_item_t pay;
		out_item_t vrd;
	} push_t;

endpackage
`default_nettype wire

/* rtl/udpdns_cfg.sv */
// apb register block holding the dns port number
`default_nettype none
module udpdns_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [udpdns_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output logic [15:0]                         match_port
);

	logic [15:0] match_port_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr == udpdns_pkg::ADDR_MATCH_PORT);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_port_q <= udpdns_pkg::MATCH_PORT_RESET;
		end else if (wr_en) begin
			match_port_q <= pwdata[15:0];
		end
	end

	// read decode
	always_comb begin
		unique case (paddr)
			udpdns_pkg::ADDR_MATCH_PORT: prdata = {16'd0, match_port_q};
			default:                     prdata = 32'd0;
		endcase
	end

	assign match_port = match_port_q;

endmodule
`default_nettype wire

/* rtl/udpdns_parse.sv */
// input register, per-packet header state and result generation
`default_nettype none
module udpdns_parse (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire udpdns_pkg::in_item_t in_data,
	input  wire logic [15:0]          match_port,
	input  wire logic                 room,
	output udpdns_pkg::push_t         push
);

	// input stage
	logic                 valid_s1;
	udpdns_pkg::in_item_t item_s1;
	logic                 advance;

	// packet state
	logic [15:0] byte_offset_q;
	logic [5:0]  ihl_q;
	logic        chk_q;
	logic [7:0]  partial_q;
	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [15:0] hw_q [4];

	// next state
	logic [15:0] off;
	logic        start;
	logic [7:0]  b;
	logic [15:0] byte_offset_d;
	logic [5:0]  ihl_d;
	logic        chk_d;
	logic [31:0] src_addr_d;
	logic [31:0] dst_addr_d;
	logic [15:0] src_port_d;
	logic [15:0] dst_port_d;
	logic [15:0] hw_d [4];
	logic [7:0]  partial_base;
	logic [15:0] word;
	logic [15:0] ihl16;
	logic [15:0] dns_off;
	logic [15:0] rel_off;
	logic [16:0] pkt_len;
	logic [16:0] body_len;
	logic [16:0] plen_full;
	logic        hdr_ok;
	logic        pay_hit;
	logic        vrd_hit;
	logic        vrd_ok;

	assign advance  = valid_s1 & room;
	assign in_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// byte decode and field capture
	always_comb begin
		b     = item_s1.pkt_byte;
		off   = item_s1.first_byte ? 16'd0 : byte_offset_q;
		start = (off == 16'd0);

		ihl_d        = start ? {b[3:0], 2'b00} : ihl_q;
		chk_d        = start ? ((b[7:4] == udpdns_pkg::IP_VERSION_4[3:0]) &&
		                        ({b[3:0], 2'b00} >= udpdns_pkg::IP_HDR_MIN)) : chk_q;
		src_addr_d   = start ? 32'd0 : src_addr_q;
		dst_addr_d   = start ? 32'd0 : dst_addr_q;
		src_port_d   = start ? 16'd0 : src_port_q;
		dst_port_d   = start ? 16'd0 : dst_port_q;
		partial_base = start ? 8'd0 : partial_q;
		for (int i = 0; i < 4; i++) begin
			hw_d[i] = start ? 16'd0 : hw_q[i];
		end

		ihl16   = {10'd0, ihl_d};
		dns_off = ihl16 + {9'd0, udpdns_pkg::UDP_HDR_LEN};
		rel_off = off - dns_off;
		word    = {partial_base, b};

		// fragment and protocol checks
		if (off == udpdns_pkg::OFF_FRAG_HI && b[5:0] != 6'd0) begin
			chk_d = 1'b0;
		end
		if (off == udpdns_pkg::OFF_FRAG_LO && b != 8'd0) begin
			chk_d = 1'b0;
		end
		if (off == udpdns_pkg::OFF_PROTO && b != udpdns_pkg::IP_PROTO_UDP) begin
			chk_d = 1'b0;
		end

		// address octets
		if (off >= udpdns_pkg::OFF_SRC_ADDR && off < udpdns_pkg::OFF_DST_ADDR) begin
			src_addr_d = {src_addr_d[23:0], b};
		end
		if (off >= udpdns_pkg::OFF_DST_ADDR && off < udpdns_pkg::OFF_ADDR_END) begin
			dst_addr_d = {dst_addr_d[23:0], b};
		end

		// 16-bit words complete on odd offsets
		if (off >= udpdns_pkg::OFF_ADDR_END && off[0]) begin
			if (off == ihl16 + 16'd1) begin
				src_port_d = word;
			end else if (off == ihl16 + 16'd3) begin
				dst_port_d = word;
				if (src_port_d != match_port && word != match_port) begin
					chk_d = 1'b0;
				end
			end else if (off >= dns_off + 16'd1 && off <= dns_off + 16'd7) begin
				hw_d[rel_off[2:1]] = word;
			end
		end

		hdr_ok = chk_d && (ihl_d >= udpdns_pkg::IP_HDR_MIN);

		// tentative payload byte
		pay_hit = hdr_ok && (off >= dns_off) &&
		          ({1'b0, rel_off} < 17'(udpdns_pkg::PAYLOAD_SIZE));

		// verdict at the last byte
		pkt_len   = {1'b0, off} + 17'd1;
		body_len  = pkt_len - {1'b0, dns_off};
		plen_full = body_len & udpdns_pkg::PAYLOAD_MASK;
		vrd_hit   = item_s1.last_byte && hdr_ok && (off >= ihl16 + 16'd3);
		vrd_ok    = (pkt_len >= {1'b0, dns_off} + {10'd0, udpdns_pkg::DNS_HDR_LEN}) &&
		            (plen_full != 17'd0);

		// offset of the next byte
		if (item_s1.last_byte) begin
			byte_offset_d = 16'd0;
		end else if (off < udpdns_pkg::OFF_MAX) begin
			byte_offset_d = off + 16'd1;
		end else begin
			byte_offset_d = udpdns_pkg::OFF_MAX;
		end

		// result beats
		push              = '0;
		push.pay_vld      = advance & pay_hit;
		push.vrd_vld      = advance & vrd_hit;
		push.pay.kind     = udpdns_pkg::KIND_PAYLOAD;
		push.pay.payload_byte = b;
		if (vrd_ok) begin
			push.vrd.kind           = udpdns_pkg::KIND_EVENT;
			push.vrd.src_addr       = src_addr_d;
			push.vrd.dst_addr       = dst_addr_d;
			push.vrd.src_port       = src_port_d;
			push.vrd.dst_port       = dst_port_d;
			push.vrd.dns_ident      = hw_d[0];
			push.vrd.dns_flags      = hw_d[1];
			push.vrd.question_count = hw_d[2];
			push.vrd.answer_count   = hw_d[3];
			push.vrd.msg_len        = plen_full[8:0];
			push.vrd.timestamp      = item_s1.time_now;
		end else begin
			push.vrd.kind = udpdns_pkg::KIND_DISCARD;
		end
	end

	// packet state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= 16'd0;
			ihl_q         <= 6'd0;
			chk_q         <= 1'b0;
			partial_q     <= 8'd0;
			src_addr_q    <= 32'd0;
			dst_addr_q    <= 32'd0;
			src_port_q    <= 16'd0;
			dst_port_q    <= 16'd0;
			for (int i = 0; i < 4; i++) begin
				hw_q[i] <= 16'd0;
			end
		end else if (advance) begin
			byte_offset_q <= byte_offset_d;
			ihl_q         <= ihl_d;
			chk_q         <= chk_d;
			partial_q     <= b;
			src_addr_q    <= src_addr_d;
			dst_addr_q    <= dst_addr_d;
			src_port_q    <= src_port_d;
			dst_port_q    <= dst_port_d;
			for (int i = 0; i < 4; i++) begin
				hw_q[i] <= hw_d[i];
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/udpdns_outq.sv */
// small result queue taking up to two beats per cycle
`default_nettype none
module udpdns_outq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire udpdns_pkg::push_t     push,
	output logic                       room,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output udpdns_pkg::out_item_t      out_data
);

	udpdns_pkg::out_item_t            entry_q [udpdns_pkg::QUEUE_DEPTH];
	logic [udpdns_pkg::QPTR_W-1:0]    wr_q;
	logic [udpdns_pkg::QPTR_W-1:0]    rd_q;
	logic [udpdns_pkg::QCNT_W-1:0]    cnt_q;
	logic [udpdns_pkg::QPTR_W-1:0]    wr_vrd;
	logic                             pop;
	logic [udpdns_pkg::QCNT_W-1:0]    n_push;

	assign out_valid = (cnt_q != '0);
	assign out_data  = entry_q[rd_q];
	assign pop       = out_valid & out_ready;
	assign room      = (cnt_q <= udpdns_pkg::QCNT_W'(udpdns_pkg::QUEUE_DEPTH - 2));
	assign wr_vrd    = wr_q + udpdns_pkg::QPTR_W'(push.pay_vld);
	assign n_push    = udpdns_pkg::QCNT_W'(push.pay_vld) + udpdns_pkg::QCNT_W'(push.vrd_vld);

	// entry writes, payload beat ahead of verdict
	always_ff @(posedge clk) begin
		if (push.pay_vld) begin
			entry_q[wr_q] <= push.pay;
		end
		if (push.vrd_vld) begin
			entry_q[wr_vrd] <= push.vrd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + udpdns_pkg::QPTR_W'(n_push);
			rd_q  <= rd_q + udpdns_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + n_push - udpdns_pkg::QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

/* rtl/udp_dns_packet_extractor.sv */
// top level of the ipv4 udp dns header extractor
//
//   channel   dir   handshake                     beat
//   in        in    in_valid / in_ready           one packet byte with marks and time
//   out       out   out_valid / out_ready         one result: payload byte, event or discard
//   apb       in    psel, penable, pwrite, pready match port register at address 0
//
// a byte is taken into the input register and processed from it; one byte per
// cycle while the result queue has room for two beats
// a byte that yields both a payload beat and a verdict puts two beats in the queue,
// while the output side drains one beat per cycle when out_ready is high
// out_valid is high while the four-entry result queue holds a beat; in_ready drops while
// a byte waits in the input register and the queue holds three or more beats
// reset clears the packet state and the queue and sets the match port to 53
`default_nettype none
module udp_dns_packet_extractor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire udpdns_pkg::in_item_t           in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output udpdns_pkg::out_item_t               out_data,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [udpdns_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic [15:0]       match_port;
	logic              room;
	udpdns_pkg::push_t push;

	// configuration register
	udpdns_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.match_port (match_port)
	);

	// byte parser
	udpdns_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.match_port (match_port),
		.room       (room),
		.push       (push)
	);

	// result queue
	udpdns_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
